[rtl/ilp_pkg.sv]
// Shared types and constants for the integer literal parser.
// No dependencies; imported by every other file of the block.
package ilp_pkg;

	localparam int MAX_DIGITS_DEF = 79;
	localparam int VALUE_W = 64;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_OCT = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_TOO_MANY  = 2'd2
	} status_t;

	typedef struct packed {
		status_t              status;
		logic                 is_signed;
		logic [VALUE_W-1:0]   value;
	} result_t;

endpackage

[rtl/integer_literal_parser.sv]
// Top level of the streaming integer literal parser: input register, parser core, result register.
// Depends on ilp_pkg and ilp_core.
//
// Takes one text byte per cycle while in_ready is high and returns one result item on the
// byte that ends a literal (that byte is not consumed into the literal). Throughput is one
// item per clock while no result is held waiting for out_ready; a result is registered:
// the byte sits in the input register until the core steps on it, and the result register
// loads at the edge where the core steps. The per-byte loop is the parser state register
// closed through a single multiply-accumulate by the radix (shift-add). The input side
// keeps accepting while a result waits to be taken, as long as the input register is empty.
module integer_literal_parser #(
	parameter int MAX_DIGITS = ilp_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  ch,
	input  logic                        first,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        is_signed,
	output logic [ilp_pkg::VALUE_W-1:0] value
);
	import ilp_pkg::*;

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               first_s1;
	logic               proc;
	logic               res_valid;
	result_t            res;
	logic               out_valid_q;
	result_t            out_q;

	assign proc = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1 <= ch;
			first_s1 <= first;
		end
	end

	ilp_core #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (proc),
		.ch        (ch_s1),
		.first     (first_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign is_signed = out_q.is_signed;
	assign value = out_q.value;

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with no item held");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> ((value == '0) && !is_signed))
		else $error("error result carries nonzero fields");

	a_sign_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && first_s1 && (ch_s1 == 8'h2D)) |=> !out_valid)
		else $error("leading minus produced a result");

endmodule

[rtl/ilp_mac.sv]
// Digit decode and multiply-accumulate by the radix, with 64-bit overflow detect.
// Depends on ilp_pkg.
module ilp_mac (
	input  ilp_pkg::radix_t            radix,
	input  logic [ilp_pkg::VALUE_W-1:0] acc,
	input  logic [7:0]                 ch,
	output logic                       is_digit,
	output logic                       ovf,
	output logic [ilp_pkg::VALUE_W-1:0] sum
);
	import ilp_pkg::*;

	localparam int PROD_W = VALUE_W + 4;

	logic [7:0]        lc;
	logic [4:0]        dval;
	logic              dval_ok;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] full;

	always_comb begin
		lc = ((ch >= "A") && (ch <= "Z")) ? (ch + 8'd32) : ch;
		dval_ok = 1'b1;
		dval = 5'd0;
		if ((lc >= "0") && (lc <= "9")) begin
			dval = 5'(lc - "0");
		end else if ((lc >= "a") && (lc <= "f")) begin
			dval = 5'(lc - "a") + 5'd10;
		end else begin
			dval_ok = 1'b0;
		end
		case (radix)
			RX_HEX: is_digit = dval_ok;
			RX_DEC: is_digit = dval_ok && (dval < 5'd10);
			RX_OCT: is_digit = dval_ok && (dval < 5'd8);
			RX_BIN: is_digit = dval_ok && (dval < 5'd2);
			default: is_digit = 1'b0;
		endcase
		case (radix)
			RX_HEX: prod = {acc, 4'b0000};
			RX_OCT: prod = {1'b0, acc, 3'b000};
			RX_BIN: prod = {3'b000, acc, 1'b0};
			default: prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
		endcase
		full = prod + PROD_W'(dval);
		ovf = |full[PROD_W-1:VALUE_W];
		sum = full[VALUE_W-1:0];
	end

endmodule

[rtl/ilp_core.sv]
// Parser state and per-byte next-state logic; emits at most one result per byte.
// Depends on ilp_pkg and ilp_mac.
module ilp_core #(
	parameter int MAX_DIGITS = ilp_pkg::MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       ch,
	input  logic             first,
	output logic             res_valid,
	output ilp_pkg::result_t res
);
	import ilp_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_DOLLAR = "$";
	localparam logic [7:0] CH_UNDER = "_";

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_ZERO   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TAIL   = 3'd4
	} phase_t;

	phase_t             phase_q, e_phase, n_phase;
	radix_t             radix_q, e_radix, n_radix;
	logic               minus_q, e_minus, n_minus;
	logic [VALUE_W-1:0] acc_q, e_acc, n_acc;
	logic               ovf_q, e_ovf, n_ovf;
	logic [CNT_W-1:0]   cnt_q, e_cnt, n_cnt, cnt_use;
	logic               su_q, e_su, n_su;
	logic               si_q, e_si, n_si;

	logic               emit;
	status_t            emit_status;
	logic               dig;
	logic               is_dec;
	logic               mac_digit;
	logic               mac_ovf;
	logic [VALUE_W-1:0] mac_sum;
	logic               sgn;
	logic [VALUE_W-1:0] mag;

	ilp_mac u_mac (
		.radix    (e_radix),
		.acc      (e_acc),
		.ch       (ch),
		.is_digit (mac_digit),
		.ovf      (mac_ovf),
		.sum      (mac_sum)
	);

	always_comb begin
		is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);

		e_phase = phase_q;
		e_radix = radix_q;
		e_minus = minus_q;
		e_acc   = acc_q;
		e_ovf   = ovf_q;
		e_cnt   = cnt_q;
		e_su    = su_q;
		e_si    = si_q;
		if (first) begin
			e_phase = PH_PREFIX;
			e_radix = RX_DEC;
			e_minus = 1'b0;
			e_acc   = '0;
			e_ovf   = 1'b0;
			e_cnt   = '0;
			e_su    = 1'b0;
			e_si    = 1'b0;
		end

		n_phase = e_phase;
		n_radix = e_radix;
		n_minus = e_minus;
		n_acc   = e_acc;
		n_ovf   = e_ovf;
		n_cnt   = e_cnt;
		n_su    = e_su;
		n_si    = e_si;
		emit = 1'b0;
		emit_status = ST_OK;
		dig = 1'b0;
		cnt_use = (e_phase == PH_ZERO) ? CNT_W'(1) : e_cnt;

		if (first && (ch == CH_MINUS)) begin
			n_minus = 1'b1;
		end else if (!(first && (ch == CH_PLUS))) begin
			case (e_phase)
				PH_PREFIX: begin
					if (ch == CH_ZERO) begin
						n_phase = PH_ZERO;
					end else if (ch == CH_DOLLAR) begin
						n_radix = RX_HEX;
						n_phase = PH_DIGITS;
					end else begin
						n_phase = PH_DIGITS;
						dig = 1'b1;
					end
				end
				PH_ZERO: begin
					n_phase = PH_DIGITS;
					if ((ch == "x") || (ch == "X")) begin
						n_radix = RX_HEX;
					end else if ((ch == "b") || (ch == "B")) begin
						n_radix = RX_BIN;
					end else if ((ch == "o") || (ch == "O")) begin
						n_radix = RX_OCT;
					end else if ((ch == "d") || (ch == "D")) begin
						n_radix = RX_DEC;
					end else begin
						n_cnt = CNT_W'(1);
						dig = 1'b1;
					end
				end
				PH_DIGITS: begin
					dig = 1'b1;
				end
				PH_TAIL: begin
					if (!is_dec) begin
						emit = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (dig) begin
				if (ch == CH_UNDER) begin
				end else if (mac_digit) begin
					if (cnt_use >= CNT_W'(MAX_DIGITS)) begin
						emit = 1'b1;
						emit_status = ST_TOO_MANY;
					end else begin
						if (mac_ovf) begin
							n_ovf = 1'b1;
						end else begin
							n_acc = mac_sum;
						end
						n_cnt = cnt_use + CNT_W'(1);
					end
				end else if (cnt_use == '0) begin
					emit = 1'b1;
					emit_status = ST_NO_DIGITS;
				end else if ((ch == "u") || (ch == "U")) begin
					n_su = 1'b1;
					n_phase = PH_TAIL;
				end else if ((ch == "i") || (ch == "I")) begin
					n_si = 1'b1;
					n_phase = PH_TAIL;
				end else if (is_dec) begin
					n_phase = PH_TAIL;
				end else begin
					emit = 1'b1;
				end
			end
		end

		sgn = !e_su && (e_si || e_minus);
		mag = e_ovf ? '1 : e_acc;
		res.status = emit_status;
		res.is_signed = 1'b0;
		res.value = '0;
		if (emit_status == ST_OK) begin
			res.is_signed = sgn;
			res.value = (sgn && e_minus) ? (VALUE_W'(0) - mag) : mag;
		end
		res_valid = step && emit;

		if (emit) begin
			n_phase = PH_IDLE;
			n_radix = RX_DEC;
			n_minus = 1'b0;
			n_acc   = '0;
			n_ovf   = 1'b0;
			n_cnt   = '0;
			n_su    = 1'b0;
			n_si    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			radix_q <= RX_DEC;
			minus_q <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			su_q    <= 1'b0;
			si_q    <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			radix_q <= n_radix;
			minus_q <= n_minus;
			acc_q   <= n_acc;
			ovf_q   <= n_ovf;
			cnt_q   <= n_cnt;
			su_q    <= n_su;
			si_q    <= n_si;
		end
	end

endmodule

[verif/tb_integer_literal_parser.sv]
// Testbench for integer_literal_parser: directed and random literal text with paced handshakes,
// each result checked against an in-bench parse of the same bytes.
// Depends on ilp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_integer_literal_parser;
	import ilp_pkg::*;

	class literal_scoreboard;
		typedef enum {WAIT_START, AFTER_SIGN, LEAD_ZERO, IN_DIGITS, IN_TAIL} parse_phase_t;

		parse_phase_t phase;
		radix_t       radix;
		bit           neg;
		bit           ovf;
		bit           sfx_u;
		bit           sfx_i;
		bit [63:0]    acc;
		int           ndig;
		result_t      expected_q[$];
		int           errors;
		int           checked;
		int           by_status[3];

		function new();
			clear();
			errors = 0;
			checked = 0;
			by_status = '{0, 0, 0};
		endfunction

		function void clear();
			phase = WAIT_START;
			radix = RX_DEC;
			neg = 1'b0;
			ovf = 1'b0;
			sfx_u = 1'b0;
			sfx_i = 1'b0;
			acc = '0;
			ndig = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit is_dec(bit [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function int digit_of(bit [7:0] c);
			bit [7:0] lc;
			int v;
			lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
			v = -1;
			if (is_dec(lc))
				v = lc - "0";
			else if (lc >= "a" && lc <= "f")
				v = lc - "a" + 10;
			if (v < 0)
				return -1;
			case (radix)
				RX_HEX: return v;
				RX_DEC: return v < 10 ? v : -1;
				RX_OCT: return v < 8 ? v : -1;
				default: return v < 2 ? v : -1;
			endcase
		endfunction

		function bit [63:0] radix_base();
			case (radix)
				RX_HEX: return 64'd16;
				RX_OCT: return 64'd8;
				RX_BIN: return 64'd2;
				default: return 64'd10;
			endcase
		endfunction

		function void close_literal(status_t st);
			result_t   res;
			bit        sgn;
			bit [63:0] mag;
			res.status = st;
			res.is_signed = 1'b0;
			res.value = '0;
			if (st == ST_OK) begin
				sgn = !sfx_u && (sfx_i || neg);
				mag = ovf ? '1 : acc;
				if (sgn && neg)
					mag = 64'd0 - mag;
				res.is_signed = sgn;
				res.value = mag;
			end
			expected_q.push_back(res);
			clear();
		endfunction

		function void note_byte(bit [7:0] c, bit f);
			bit        again;
			int        d;
			bit [63:0] dv;
			bit [63:0] r;
			if (f) begin
				clear();
				phase = AFTER_SIGN;
				if (c == "-") begin
					neg = 1'b1;
					return;
				end
				if (c == "+")
					return;
			end
			do begin
				again = 1'b0;
				case (phase)
					AFTER_SIGN: begin
						if (c == "0") begin
							phase = LEAD_ZERO;
						end else if (c == "$") begin
							radix = RX_HEX;
							phase = IN_DIGITS;
						end else begin
							phase = IN_DIGITS;
							again = 1'b1;
						end
					end
					LEAD_ZERO: begin
						phase = IN_DIGITS;
						if (c == "x" || c == "X")
							radix = RX_HEX;
						else if (c == "b" || c == "B")
							radix = RX_BIN;
						else if (c == "o" || c == "O")
							radix = RX_OCT;
						else if (c == "d" || c == "D")
							radix = RX_DEC;
						else begin
							acc = '0;
							ndig = 1;
							again = 1'b1;
						end
					end
					IN_DIGITS: begin
						d = digit_of(c);
						if (c == "_") begin
						end else if (d >= 0) begin
							if (ndig >= MAX_DIGITS_DEF) begin
								close_literal(ST_TOO_MANY);
							end else begin
								r = radix_base();
								dv = d;
								if (acc > (~64'd0 - dv) / r)
									ovf = 1'b1;
								else
									acc = acc * r + dv;
								ndig++;
							end
						end else if (ndig == 0) begin
							close_literal(ST_NO_DIGITS);
						end else if (c == "u" || c == "U") begin
							sfx_u = 1'b1;
							phase = IN_TAIL;
						end else if (c == "i" || c == "I") begin
							sfx_i = 1'b1;
							phase = IN_TAIL;
						end else if (is_dec(c)) begin
							phase = IN_TAIL;
						end else begin
							close_literal(ST_OK);
						end
					end
					IN_TAIL: begin
						if (!is_dec(c))
							close_literal(ST_OK);
					end
					default: ;
				endcase
			end while (again);
		endfunction

		task report_mismatch(string msg);
			if (errors < 50)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic sg, logic [63:0] v);
			result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d value=%h", st, v));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", st, want.status));
			if (sg !== want.is_signed)
				report_mismatch($sformatf("is_signed %b, want %b", sg, want.is_signed));
			if (v !== want.value)
				report_mismatch($sformatf("value %h, want %h", v, want.value));
			if (want.status <= ST_TOO_MANY)
				by_status[want.status]++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        first;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        is_signed;
	logic [63:0] value;

	literal_scoreboard sb = new();
	int send_idle_pct = 32;
	int recv_idle_pct = 60;
	int sent_bytes = 0;
	int literals = 0;

	integer_literal_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.first(first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_signed(is_signed),
		.value(value)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_byte(ch, first);
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, is_signed, value);
	end

	task automatic send_byte(input logic [7:0] c, input logic f);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		ch = c;
		first = f;
		do @(posedge clk); while (!in_ready);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == 0);
		literals++;
	endtask

	function automatic logic [7:0] rand_digit(radix_t rx);
		int v;
		case (rx)
			RX_HEX: v = $urandom_range(0, 15);
			RX_OCT: v = $urandom_range(0, 7);
			RX_BIN: v = $urandom_range(0, 1);
			default: v = $urandom_range(0, 9);
		endcase
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	task automatic send_random_literal();
		logic [7:0] q[$];
		radix_t     rx;
		int         n;
		int         kind;
		rx = RX_DEC;
		case ($urandom_range(0, 3))
			1: q.push_back("-");
			2: q.push_back("+");
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: begin
				q.push_back("0");
				q.push_back($urandom_range(0, 1) ? "x" : "X");
				rx = RX_HEX;
			end
			1: begin
				q.push_back("0");
				q.push_back($urandom_range(0, 1) ? "b" : "B");
				rx = RX_BIN;
			end
			2: begin
				q.push_back("0");
				q.push_back($urandom_range(0, 1) ? "o" : "O");
				rx = RX_OCT;
			end
			3: begin
				q.push_back("0");
				q.push_back($urandom_range(0, 1) ? "d" : "D");
			end
			4: begin
				q.push_back("$");
				rx = RX_HEX;
			end
			default: ;
		endcase
		kind = $urandom_range(0, 99);
		if (kind < 5)
			n = 0;
		else if (kind < 10)
			n = $urandom_range(MAX_DIGITS_DEF - 2, MAX_DIGITS_DEF + 2);
		else if (kind < 22)
			n = $urandom_range(15, 30);
		else
			n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 10)
				q.push_back("_");
			q.push_back(rand_digit(rx));
		end
		case ($urandom_range(0, 7))
			0: q.push_back("u");
			1: q.push_back("U");
			2: q.push_back("i");
			3: q.push_back("I");
			default: ;
		endcase
		repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
			q.push_back(8'("0" + $urandom_range(0, 9)));
		if (q.size() > 0 && $urandom_range(0, 9) == 0)
			q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: q.push_back(8'h00);
			1: q.push_back(" ");
			2: q.push_back(",");
			3: q.push_back(8'($urandom_range(0, 255)));
			4: ;
			default: q.push_back(")");
		endcase
		if (q.size() == 0)
			q.push_back(" ");
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
			q.push_back(8'($urandom_range(0, 255)));
		foreach (q[i])
			send_byte(q[i], i == 0);
		literals++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		ch = 8'h00;
		first = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 32 : (m == 1) ? 60 : 0;
			recv_idle_pct = (m == 0) ? 60 : (m == 1) ? 32 : 0;
			if (m == 0) begin
				send_text("-0x1F_i7,");
				send_text("$z");
				send_text("09 ");
				send_text("0o7u");
				send_byte(8'h00, 1'b0);
				send_text("+1");
				send_byte(8'hFF, 1'b0);
				send_text("12");
				send_text("5 ");
				send_byte("q", 1'b0);
			end
			while (sent_bytes < (m + 1) * 280) begin
				if ($urandom_range(0, 99) < 12) begin
					repeat ($urandom_range(1, 4))
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end else begin
					send_random_literal();
				end
			end
		end

		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d text bytes forming %0d literals across three pacing modes",
			sent_bytes, literals);
		$display("Checked %0d results (%0d ok, %0d no digits, %0d too many), %0d mismatches",
			sb.checked, sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout waiting for the parser");
		$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
rtl/ilp_pkg.sv
rtl/ilp_mac.sv
rtl/ilp_core.sv
rtl/integer_literal_parser.sv
verif/tb_integer_literal_parser.sv
